// File: rtl/core/pic_pkg.sv
// ----------------------------------------------------------------------------
// pic_pkg
// shared widths and defaults for the image checksum block
// ----------------------------------------------------------------------------
package pic_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned SUM_W           = 33;
  localparam int unsigned TAIL_W          = 2;
  localparam int unsigned SKIP_W          = 24;
  localparam int unsigned INDEX_BITS_DEF  = 24;
  localparam int unsigned S_TDATA_W       = 40;
  localparam int unsigned M_TDATA_W       = 32;

  localparam logic [SUM_W-1:0] SUM_LIMIT  = 33'h1_0000_0000;

endpackage

// File: rtl/core/pe_image_checksum.sv
// ----------------------------------------------------------------------------
// pe_image_checksum
// streaming executable image checksum: end-around-carry word sum with one
// skipped word, folded to 16 bits and added to the image byte length
// result: the last word is registered at the input, then its checksum at the output
// throughput: one word per cycle if not stalled, set by the single sum/fold pass
// reset clears the running sum, word index, skip index and all valids
// ----------------------------------------------------------------------------
module pe_image_checksum
  import pic_pkg::*;
#(
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [SKIP_W-1:0]    cfg_data_i,     // skip_word_index

  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // data_word [31:0], tail_bytes [33:32]
  input  logic                 s_axis_tlast,

  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata    // checksum [31:0]
);

  localparam int unsigned CMP_W = (INDEX_BITS > SKIP_W) ? INDEX_BITS : SKIP_W;

  logic                  in_vld_q;
  logic [WORD_W-1:0]     in_word_q;
  logic [TAIL_W-1:0]     in_tail_q;
  logic                  in_last_q;

  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [INDEX_BITS-1:0] idx_q, idx_d;
  logic [SKIP_W-1:0]     skip_q;

  logic                  out_vld_q;
  logic [WORD_W-1:0]     out_data_q, out_data_d;

  logic                  process;
  logic                  s_acc;
  logic                  skip_hit;
  logic [SUM_W-1:0]      add_raw;
  logic [SUM_W-1:0]      add_fold;
  logic [SUM_W-1:0]      sum_new;
  logic [INDEX_BITS-1:0] idx_inc;
  logic [17:0]           fold1;
  logic [15:0]           fold2;
  logic [WORD_W-1:0]     length;

  assign process       = in_vld_q && (!in_last_q || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || process;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    skip_hit = (CMP_W'(idx_q) == CMP_W'(skip_q));
    add_raw  = SUM_W'(sum_q[WORD_W-1:0]) + SUM_W'(in_word_q) + SUM_W'(sum_q[WORD_W]);
    if (add_raw > SUM_LIMIT) begin
      add_fold = SUM_W'(add_raw[WORD_W-1:0]) + SUM_W'(add_raw[WORD_W]);
    end else begin
      add_fold = add_raw;
    end
    sum_new = skip_hit ? sum_q : add_fold;
    idx_inc = INDEX_BITS'(idx_q + 1'b1);

    fold1  = 18'(sum_new[15:0]) + 18'(sum_new[SUM_W-1:16]);
    fold2  = fold1[15:0] + 16'(fold1[17:16]);
    length = (WORD_W'(idx_inc) << 2) + WORD_W'(in_tail_q);
    out_data_d = WORD_W'(fold2) + length;

    sum_d = sum_q;
    idx_d = idx_q;
    if (process) begin
      if (in_last_q) begin
        sum_d = '0;
        idx_d = '0;
      end else begin
        sum_d = sum_new;
        idx_d = idx_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      sum_q     <= '0;
      idx_q     <= '0;
      skip_q    <= '0;
    end else begin
      if (s_acc) begin
        in_vld_q <= 1'b1;
      end else if (process) begin
        in_vld_q <= 1'b0;
      end
      if (process && in_last_q) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      sum_q <= sum_d;
      idx_q <= idx_d;
      if (cfg_valid_i) begin
        skip_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_word_q <= s_axis_tdata[WORD_W-1:0];
      in_tail_q <= s_axis_tdata[WORD_W+TAIL_W-1:WORD_W];
      in_last_q <= s_axis_tlast;
    end
    if (process && in_last_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // a set carry bit leaves the low word at zero after every fold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q[WORD_W] |-> (sum_q[WORD_W-1:0] == '0))
    else $error("running sum exceeds end-around limit");

  // finishing an image clears the state and raises a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && in_last_q) |=> (m_axis_tvalid && sum_q == '0 && idx_q == '0))
    else $error("last word did not produce a result and clear state");

  // an empty input register always takes a new word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> s_axis_tready)
    else $error("input stalled with empty input register");

  // a stalled last word waits only on a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !process) |-> (in_last_q && m_axis_tvalid && !m_axis_tready))
    else $error("input register stalled without output back-pressure");

endmodule

// File: bench/pic_checksum_checker.sv
// ----------------------------------------------------------------------------
// pic_checksum_checker
// watches the config, word and checksum channels of pe_image_checksum, keeps
// its own copy of the running sum, word index and skip index, predicts one
// checksum per image and compares every result transaction in order
// ----------------------------------------------------------------------------
module pic_checksum_checker
  import pic_pkg::*;
#(
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [SKIP_W-1:0]    cfg_data_i,

  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic                 s_tlast_i,

  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [M_TDATA_W-1:0] m_tdata_i,

  output int                   pending_o,
  output int                   errors_o
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [SUM_W-1:0]      image_sum = '0;
  logic [INDEX_BITS-1:0] word_idx  = '0;
  logic [SKIP_W-1:0]     skip_idx  = '0;
  logic [M_TDATA_W-1:0]  expected_sums[$];

  initial begin
    pending_o = 0;
    errors_o  = 0;
  end

  // end-around-carry add of one word
  function automatic logic [SUM_W-1:0] add_word_eac(logic [SUM_W-1:0] acc,
                                                    logic [WORD_W-1:0] w);
    logic [SUM_W:0] s;
    s = {2'b00, acc[WORD_W-1:0]} + {2'b00, w} + {{SUM_W{1'b0}}, acc[WORD_W]};
    if (s > {1'b0, SUM_LIMIT}) begin
      s = {2'b00, s[WORD_W-1:0]} + {{WORD_W{1'b0}}, s[SUM_W:WORD_W]};
    end
    return s[SUM_W-1:0];
  endfunction

  function automatic logic [15:0] fold_to_16(logic [SUM_W-1:0] acc);
    logic [SUM_W:0] s;
    s = {18'b0, acc[15:0]} + {17'b0, acc[SUM_W-1:16]};
    s = s + (s >> 16);
    return s[15:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [WORD_W-1:0]    word;
    logic [TAIL_W-1:0]    tail;
    logic [M_TDATA_W-1:0] length;
    logic [M_TDATA_W-1:0] want;
    if (!rst_ni) begin
      image_sum <= '0;
      word_idx  <= '0;
      skip_idx  <= '0;
      expected_sums.delete();
      pending_o <= 0;
    end else begin
      // results first: a checksum can never belong to a word taken at this edge
      if (m_tvalid_i && m_tready_i) begin
        if (expected_sums.size() == 0) begin
          errors_o = errors_o + 1;
          $display("%0t: checksum mismatch, expected none, actual %08h", $realtime,
                   m_tdata_i);
        end else begin
          want = expected_sums.pop_front();
          if (m_tdata_i !== want) begin
            errors_o = errors_o + 1;
            $display("%0t: checksum mismatch, expected %08h, actual %08h", $realtime,
                     want, m_tdata_i);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        word = s_tdata_i[WORD_W-1:0];
        tail = s_tdata_i[WORD_W+TAIL_W-1:WORD_W];
        if (word_idx != skip_idx) begin
          image_sum = add_word_eac(image_sum, word);
        end
        word_idx = word_idx + 1'b1;
        if (s_tlast_i) begin
          length = M_TDATA_W'(word_idx);
          length = (length << 2) + M_TDATA_W'(tail);
          expected_sums.push_back({16'b0, fold_to_16(image_sum)} + length);
          image_sum = '0;
          word_idx  = '0;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        skip_idx <= cfg_data_i;
      end
      pending_o <= expected_sums.size();
    end
  end

endmodule

// File: bench/tb_pe_image_checksum.sv
// ----------------------------------------------------------------------------
// tb_pe_image_checksum
// drives images of random words with random gaps and back-pressure through
// pe_image_checksum, moves the skip index between phases and leaves checking
// to pic_checksum_checker; directed images cover carries, tails and skips
// ----------------------------------------------------------------------------
module tb_pe_image_checksum
  import pic_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [SKIP_W-1:0]    cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // data_word [31:0], tail_bytes [33:32]
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;         // checksum [31:0]

  int pending;
  int errors;
  int tx_gap_pct = 6;
  int rx_stall_pct = 59;

  pe_image_checksum uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  pic_checksum_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic push_word(logic [WORD_W-1:0] word, logic last, logic [TAIL_W-1:0] tail);
    while ($urandom_range(99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W-WORD_W-TAIL_W){1'b0}}, tail, word};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_skip_index(logic [SKIP_W-1:0] idx);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= idx;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(9))
      0:       return '1;
      1:       return '0;
      2:       return {16'hFFFF, 16'($urandom)};
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // a non-last word carries random tail bits, which the block must ignore
  task automatic push_mid(logic [WORD_W-1:0] word);
    push_word(word, 1'b0, TAIL_W'($urandom));
  endtask

  task automatic stream_images(int n_words);
    int sent;
    int len;
    logic [SKIP_W-1:0] idx;
    repeat (3) begin
      case ($urandom_range(5))
        0:       idx = '0;
        1:       idx = '1;
        2:       idx = SKIP_W'($urandom);
        default: idx = SKIP_W'($urandom_range(7));
      endcase
      write_skip_index(idx);
      sent = 0;
      while (sent < n_words) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
        repeat (len - 1) push_mid(random_word());
        push_word(random_word(), 1'b1, TAIL_W'($urandom));
        sent = sent + len;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // skip index at its reset value: a one-word image loses its only word
    push_word(32'hFFFF_FFFF, 1'b1, 2'd3);

    write_skip_index(24'd1);
    repeat (3) push_mid(32'hFFFF_FFFF);
    push_word(32'hFFFF_FFFF, 1'b1, 2'd0);
    push_word(32'h0000_0000, 1'b1, 2'd1);
    push_mid(32'h8000_0000);
    push_mid(32'h1234_5678);
    push_mid(32'h8000_0000);
    push_word(32'hFFFF_FFFF, 1'b1, 2'd2);

    // last word sits on the skip index
    write_skip_index(24'd3);
    push_mid(32'hA5A5_A5A5);
    push_mid(32'h5A5A_5A5A);
    push_mid(32'hFFFF_0000);
    push_word(32'hDEAD_BEEF, 1'b1, 2'd3);

    write_skip_index(24'hFF_FFFF);
    push_mid(32'hFFFF_FFFF);
    push_mid(32'hFFFF_FFFF);
    push_word(32'h0000_0001, 1'b1, 2'd2);

    write_skip_index(24'd0);
    push_mid(32'h0000_FFFF);
    push_word(32'hFFFF_0001, 1'b1, 2'd1);

    stream_images(190);

    tx_gap_pct   = 59;
    rx_stall_pct = 6;
    stream_images(190);

    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    stream_images(190);

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: files.f
rtl/core/pic_pkg.sv
rtl/core/pe_image_checksum.sv
bench/pic_checksum_checker.sv
bench/tb_pe_image_checksum.sv
